[sv/psc_pkg.sv]
// ----------------------------------------------------------------------------
// psc_pkg: shared types and constants for the pair-sum complement lookup
// Transaction payloads, the search token that walks the cell chain, and the
// counter limits used by the controller and the cells.
// ----------------------------------------------------------------------------
package psc_pkg;

   localparam int STORE_DEPTH_DEFAULT = 64;

   localparam logic [6:0] COUNT_MAX = 7'd127;   // position counter saturates here
   localparam logic [5:0] POS_MAX   = 6'd63;    // reported positions saturate here

   typedef struct packed {
      logic signed [31:0] value;
      logic               first_of_set;
      logic               last_of_set;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [5:0] earlier_position;
      logic [5:0] later_position;
      logic       overflow;
   } rsp_type;

   // Search token handed from cell to cell
   typedef struct packed {
      logic        valid;
      logic [31:0] need;       // complement being searched
      logic        in_range;   // complement fits in 32 bits signed
      logic [6:0]  count;      // entries below this index are live
      logic        hit;
      logic [5:0]  hit_pos;
   } token_type;

endpackage

[sv/pair_sum_complement_lookup.sv]
// ----------------------------------------------------------------------------
// pair_sum_complement_lookup: two-sum lookup over a streamed set
// Stores the values of a set in a chain of cells and, for each new value,
// searches the chain for target_sum minus that value.
// ----------------------------------------------------------------------------
// A set is fed one value per transaction on start/req_payload; first_of_set
// clears the store and the position counter. While a value is searched, busy
// stays high: its search token walks the cell chain one cell per clock, and
// the result (if any) is pulsed on rsp_strobe for one cycle as busy drops.
// Values arriving after a hit or after the last value of a set are dropped
// with no result. Results cannot be held off, so a receiver must take every
// rsp_strobe cycle. target_sum is written through csr_valid/csr_ready, which
// is ready whenever busy is low.
// ----------------------------------------------------------------------------
module pair_sum_complement_lookup #(
   parameter int STORE_DEPTH = psc_pkg::STORE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // request transactions
   input  logic                   start,
   output logic                   busy,
   input  psc_pkg::req_type       req_payload,
   // result transactions
   output logic                   rsp_strobe,
   output psc_pkg::rsp_type       rsp_payload,
   // target_sum register
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic signed [31:0]     csr_data
);
   import psc_pkg::*;

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   logic               busy_ff, busy_in;
   logic [6:0]         pc_ff, pc_in;           // position counter
   logic               set_done_ff, set_done_in;
   logic               cap_ff, cap_in;          // capacity exceeded
   logic [6:0]         pos_ff, pos_in;          // position of item in flight
   logic [31:0]        value_ff, value_in;
   logic               last_ff, last_in;
   logic signed [31:0] target_ff;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_ff, rsp_in;
   token_type          launch_ff, launch_in;

   // ---------------------------------------------------------------------
   // cell chain
   // ---------------------------------------------------------------------
   token_type               tok [STORE_DEPTH+1];
   logic [STORE_DEPTH-1:0]  cell_wr;
   logic [STORE_DEPTH:0]    tok_live;
   token_type               tail;
   logic                    store_we;

   assign tok[0] = launch_ff;

   genvar k;
   generate
      for (k = 0; k < STORE_DEPTH; k++) begin : g_cell
         assign cell_wr[k] = store_we && ({25'd0, pos_ff} == 32'(k));
         psc_cell #(
            .CELL_INDEX (k)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .tok_i    (tok[k]),
            .tok_o    (tok[k+1]),
            .wr_en    (cell_wr[k]),
            .wr_value (value_ff)
         );
      end
      for (k = 0; k <= STORE_DEPTH; k++) begin : g_live
         assign tok_live[k] = tok[k].valid;
      end
   endgenerate

   assign tail = tok[STORE_DEPTH];

   // ---------------------------------------------------------------------
   // controller
   // ---------------------------------------------------------------------
   logic               take;
   logic [6:0]         eff_pc;
   logic               eff_done;
   logic               eff_cap;
   logic               over;
   logic signed [32:0] need_wide;
   logic [6:0]         pc_next_sat;
   logic               pos_storable;
   logic [5:0]         later_pos;

   assign take     = start && !busy_ff;
   assign eff_pc   = req_payload.first_of_set ? 7'd0 : pc_ff;
   assign eff_done = req_payload.first_of_set ? 1'b0 : set_done_ff;
   assign eff_cap  = req_payload.first_of_set ? 1'b0 : cap_ff;
   assign over     = ({25'd0, eff_pc} >= 32'(STORE_DEPTH)) || (eff_pc >= COUNT_MAX);

   // exact complement; only fits when the two top bits agree
   assign need_wide = {target_ff[31], target_ff} - {req_payload.value[31], req_payload.value};

   assign pc_next_sat  = (pc_ff == COUNT_MAX) ? pc_ff : pc_ff + 7'd1;
   assign pos_storable = ({25'd0, pos_ff} < 32'(STORE_DEPTH)) && (pos_ff < COUNT_MAX);
   assign later_pos    = pos_ff[6] ? POS_MAX : pos_ff[5:0];
   assign store_we     = tail.valid && !tail.hit && pos_storable;

   always_comb begin
      busy_in       = busy_ff;
      pc_in         = pc_ff;
      set_done_in   = set_done_ff;
      cap_in        = cap_ff;
      pos_in        = pos_ff;
      value_in      = value_ff;
      last_in       = last_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      launch_in     = launch_ff;
      launch_in.valid = 1'b0;

      if (take) begin
         pc_in       = eff_pc;
         set_done_in = eff_done;
         cap_in      = eff_cap;
         if (!eff_done) begin
            busy_in            = 1'b1;
            pos_in             = eff_pc;
            value_in           = req_payload.value;
            last_in            = req_payload.last_of_set;
            cap_in             = eff_cap | over;
            launch_in.valid    = 1'b1;
            launch_in.need     = need_wide[31:0];
            launch_in.in_range = (need_wide[32] == need_wide[31]);
            launch_in.count    = eff_pc;
            launch_in.hit      = 1'b0;
            launch_in.hit_pos  = 6'd0;
         end
      end

      // search token leaves the chain: finish the transaction
      if (tail.valid) begin
         busy_in = 1'b0;
         pc_in   = pc_next_sat;
         if (tail.hit) begin
            set_done_in             = 1'b1;
            rsp_strobe_in           = 1'b1;
            rsp_in.found            = 1'b1;
            rsp_in.earlier_position = tail.hit_pos;
            rsp_in.later_position   = later_pos;
            rsp_in.overflow         = cap_ff;
         end else if (last_ff) begin
            set_done_in             = 1'b1;
            rsp_strobe_in           = 1'b1;
            rsp_in.found            = 1'b0;
            rsp_in.earlier_position = 6'd0;
            rsp_in.later_position   = 6'd0;
            rsp_in.overflow         = cap_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b0;
         pc_ff           <= 7'd0;
         set_done_ff     <= 1'b0;
         cap_ff          <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
         launch_ff.valid <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         pc_ff         <= pc_in;
         set_done_ff   <= set_done_in;
         cap_ff        <= cap_in;
         rsp_strobe_ff <= rsp_strobe_in;
         launch_ff     <= launch_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      value_ff <= value_in;
      last_ff  <= last_in;
      rsp_ff   <= rsp_in;
   end

   // target_sum register
   assign csr_ready = !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= 32'sd0;
      end else if (csr_valid && csr_ready) begin
         target_ff <= csr_data;
      end
   end

   assign busy        = busy_ff;
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_live))
      else $error("more than one search token in the chain");

   a_tail_busy: assert property (@(posedge clock) disable iff (reset)
      tail.valid |-> busy_ff)
      else $error("search token finished while idle");

   a_rsp_after_search: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> ($past(busy_ff) && !busy_ff))
      else $error("result not at the end of a search");

   a_pos_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_ff.found) |-> (rsp_ff.earlier_position <= rsp_ff.later_position))
      else $error("partner position after current position");

endmodule

[sv/psc_cell.sv]
// ----------------------------------------------------------------------------
// psc_cell: one storage cell of the lookup chain
// Holds one stored value, compares it against the passing search token and
// forwards the token, marked with its own position on a match.
// ----------------------------------------------------------------------------
module psc_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  psc_pkg::token_type tok_i,
   output psc_pkg::token_type tok_o,
   input  logic               wr_en,
   input  logic [31:0]        wr_value
);
   import psc_pkg::*;

   // cells at or past the counter limit can never be written
   localparam bit         CellLive = CELL_INDEX < 127;
   localparam logic [6:0] CellIdx  = CellLive ? 7'(CELL_INDEX) : 7'd0;
   localparam logic [5:0] CellPos  = (CELL_INDEX > 63) ? POS_MAX : 6'(CELL_INDEX);

   logic [31:0] entry_value_ff;
   token_type   tok_ff;
   token_type   tok_in;
   logic        match;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_value_ff <= wr_value;
      end
   end

   assign match = tok_i.valid && tok_i.in_range && CellLive && (CellIdx < tok_i.count)
                  && (entry_value_ff == tok_i.need);

   // later cells override earlier ones: latest duplicate wins
   always_comb begin
      tok_in = tok_i;
      if (match) begin
         tok_in.hit     = 1'b1;
         tok_in.hit_pos = CellPos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;

endmodule
